@@ sv/fps_pkg.sv @@
// ----------------------------------------------------------------------------
// Footprint circle package
// Shared widths, register indexes, circle codes and the types that are passed
// between the parts of the footprint circle transform.
// ----------------------------------------------------------------------------
package fps_pkg;

   localparam int LENGTH_W    = 16;
   localparam int RADIUS_W    = 17;
   localparam int SINCOS_W    = 17;
   localparam int HEADING_W   = 12;
   localparam int INDEX_W     = 3;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_FRONT_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REAR_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BODY_WIDTH   = 2'd2;

   localparam logic [INDEX_W-1:0] CIRCLE_REAR_LEFT   = 3'd0;
   localparam logic [INDEX_W-1:0] CIRCLE_REAR_RIGHT  = 3'd1;
   localparam logic [INDEX_W-1:0] CIRCLE_FRONT_LEFT  = 3'd2;
   localparam logic [INDEX_W-1:0] CIRCLE_FRONT_RIGHT = 3'd3;
   localparam logic [INDEX_W-1:0] CIRCLE_BOUND       = 3'd4;

   typedef enum logic [1:0] {
      R_IDLE,
      R_MULT,
      R_LOAD,
      R_ITER
   } radius_state_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] corner;
      logic [RADIUS_W-1:0] bound;
   } radii_type;

endpackage

@@ sv/fps_radius.sv @@
// ----------------------------------------------------------------------------
// Footprint radius unit
// Recomputes the corner and bounding radii as rounded-down square roots of the
// body dimensions, bit by bit in two parallel lanes.
// ----------------------------------------------------------------------------
module fps_radius (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fps_pkg::LENGTH_W-1:0]  front_length,
   input  logic [fps_pkg::LENGTH_W-1:0]  rear_length,
   input  logic [fps_pkg::LENGTH_W-1:0]  body_width,
   output logic                          busy,
   output fps_pkg::radii_type            radii
);

   localparam int RAD_W = 34;

   fps_pkg::radius_state_type state_ff, state_in;

   logic [31:0]        ww_ff, ww_in;
   logic [RAD_W-1:0]   ll_ff, ll_in;
   logic [RAD_W-1:0]   bit_ff, bit_in;
   logic [RAD_W-1:0]   rem_ff [2];
   logic [RAD_W-1:0]   rem_in [2];
   logic [RAD_W-1:0]   res_ff [2];
   logic [RAD_W-1:0]   res_in [2];
   logic [RAD_W:0]     trial  [2];
   logic [RAD_W:0]     bound_sum;
   logic [16:0]        len;
   fps_pkg::radii_type radii_ff, radii_in;

   assign len       = 17'(front_length) + 17'(rear_length);
   assign bound_sum = 35'(ll_ff) + 35'(ww_ff);
   assign busy      = (state_ff != fps_pkg::R_IDLE);
   assign radii     = radii_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fps_pkg::R_MULT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ww_ff    <= ww_in;
      ll_ff    <= ll_in;
      bit_ff   <= bit_in;
      radii_ff <= radii_in;
      for (int i = 0; i < 2; i++) begin
         rem_ff[i] <= rem_in[i];
         res_ff[i] <= res_in[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      ww_in    = ww_ff;
      ll_in    = ll_ff;
      bit_in   = bit_ff;
      radii_in = radii_ff;
      for (int i = 0; i < 2; i++) begin
         rem_in[i] = rem_ff[i];
         res_in[i] = res_ff[i];
         trial[i]  = 35'(res_ff[i]) + 35'(bit_ff);
      end
      case (state_ff)
         fps_pkg::R_IDLE: begin
            if (start) begin
               state_in = fps_pkg::R_MULT;
            end
         end
         fps_pkg::R_MULT: begin
            ww_in    = 32'(body_width) * 32'(body_width);
            ll_in    = 34'(len) * 34'(len);
            state_in = fps_pkg::R_LOAD;
         end
         fps_pkg::R_LOAD: begin
            rem_in[0] = {5'd0, ww_ff[31:3]};
            rem_in[1] = {1'b0, bound_sum[RAD_W:2]};
            res_in[0] = '0;
            res_in[1] = '0;
            bit_in    = {2'b01, {(RAD_W-2){1'b0}}};
            state_in  = fps_pkg::R_ITER;
         end
         fps_pkg::R_ITER: begin
            for (int i = 0; i < 2; i++) begin
               if ({1'b0, rem_ff[i]} >= trial[i]) begin
                  rem_in[i] = rem_ff[i] - trial[i][RAD_W-1:0];
                  res_in[i] = (res_ff[i] >> 1) + bit_ff;
               end else begin
                  res_in[i] = res_ff[i] >> 1;
               end
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               radii_in.corner = res_in[0][fps_pkg::RADIUS_W-1:0];
               radii_in.bound  = res_in[1][fps_pkg::RADIUS_W-1:0];
               state_in        = fps_pkg::R_IDLE;
            end
         end
         default: begin
            state_in = fps_pkg::R_IDLE;
         end
      endcase
   end

endmodule

@@ sv/fps_front.sv @@
// ----------------------------------------------------------------------------
// Footprint front end
// Accepts poses, looks up sine and cosine of the heading in the quarter-wave
// table and hands the pose with its signed sine and cosine to the queue.
// ----------------------------------------------------------------------------
module fps_front #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int COORD_BITS       = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              busy,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [COORD_BITS-1:0]      req_pose_x,
   input  logic signed [COORD_BITS-1:0]      req_pose_y,
   input  logic [fps_pkg::HEADING_W-1:0]     req_pose_heading,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [2*COORD_BITS+2*fps_pkg::SINCOS_W-1:0] q_data
);

   localparam int KW   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int KP_W = KW + 10;

   typedef logic [15:0] rom_type [0:SINE_TABLE_DEPTH];

   typedef enum logic [1:0] {
      Q_FIRST,
      Q_SECOND,
      Q_THIRD,
      Q_FOURTH
   } quad_type;

   function automatic logic [15:0] sine_entry(input longint unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned r;
      x    = (64'd1686629713 * k) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      sum  = longint'(x);
      term = ((x * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = (longint'(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      return r[15:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         t[k] = sine_entry(longint'(k));
      end
      return t;
   endfunction

   localparam rom_type SIN_ROM = build_rom();

   logic                          f1_valid_ff, f1_valid_in;
   logic                          f2_valid_ff, f2_valid_in;
   logic signed [COORD_BITS-1:0]  px1_ff, py1_ff, px2_ff, py2_ff;
   quad_type                      quad1_ff, quad2_ff;
   logic [KW-1:0]                 k1_ff;
   logic [15:0]                   a_ff, b_ff;
   logic [KP_W-1:0]               kprod;
   logic                          adv1, adv2, accept;
   logic signed [fps_pkg::SINCOS_W-1:0] a_s, b_s, sin_v, cos_v;

   assign adv2     = !f2_valid_ff || !q_full;
   assign adv1     = !f1_valid_ff || adv2;
   assign req_full = busy || !adv1;
   assign accept   = req_push && !req_full;
   assign kprod    = KP_W'(req_pose_heading[9:0]) * KP_W'(SINE_TABLE_DEPTH);

   always_comb begin
      f1_valid_in = f1_valid_ff;
      f2_valid_in = f2_valid_ff;
      if (adv2) begin
         f2_valid_in = f1_valid_ff;
      end
      if (adv1) begin
         f1_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff   <= req_pose_x;
         py1_ff   <= req_pose_y;
         quad1_ff <= quad_type'(req_pose_heading[11:10]);
         k1_ff    <= kprod[KP_W-1:10];
      end
      if (adv2) begin
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         quad2_ff <= quad1_ff;
         a_ff     <= SIN_ROM[k1_ff];
         b_ff     <= SIN_ROM[KW'(SINE_TABLE_DEPTH) - k1_ff];
      end
   end

   assign a_s = {1'b0, a_ff};
   assign b_s = {1'b0, b_ff};

   always_comb begin
      case (quad2_ff)
         Q_FIRST: begin
            sin_v = a_s;
            cos_v = b_s;
         end
         Q_SECOND: begin
            sin_v = b_s;
            cos_v = -a_s;
         end
         Q_THIRD: begin
            sin_v = -a_s;
            cos_v = -b_s;
         end
         default: begin
            sin_v = -b_s;
            cos_v = a_s;
         end
      endcase
   end

   assign q_push = f2_valid_ff && !q_full;
   assign q_data = {px2_ff, py2_ff, sin_v, cos_v};

endmodule

@@ sv/fps_queue.sv @@
// ----------------------------------------------------------------------------
// Footprint request queue
// A two-entry first-in first-out buffer between the front end and the back
// end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module fps_queue #(
   parameter int WIDTH = 82
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/fps_back.sv @@
// ----------------------------------------------------------------------------
// Footprint back end
// Steps through the five circles of each queued request, one a cycle if free,
// and rotates, rounds, translates and saturates each centre in three stages.
// ----------------------------------------------------------------------------
module fps_back #(
   parameter int COORD_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  logic [2*COORD_BITS+2*fps_pkg::SINCOS_W-1:0] q_data,
   output logic                              q_pop,
   input  logic [fps_pkg::LENGTH_W-1:0]      front_length,
   input  logic [fps_pkg::LENGTH_W-1:0]      rear_length,
   input  logic [fps_pkg::LENGTH_W-1:0]      body_width,
   input  fps_pkg::radii_type                radii,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [fps_pkg::INDEX_W-1:0]       rsp_circle_index,
   output logic signed [COORD_BITS-1:0]      rsp_center_x,
   output logic signed [COORD_BITS-1:0]      rsp_center_y,
   output logic [fps_pkg::RADIUS_W-1:0]      rsp_radius,
   output logic                              rsp_last_circle
);

   localparam int SC_W   = fps_pkg::SINCOS_W;
   localparam int QW     = 2*COORD_BITS + 2*SC_W;
   localparam int PROD_W = 37;
   localparam int DX_W   = 22;
   localparam int SUM_W  = (COORD_BITS > DX_W ? COORD_BITS : DX_W) + 1;

   function automatic logic signed [COORD_BITS-1:0] saturate(
      input logic signed [SUM_W-1:0] v
   );
      logic [SUM_W-COORD_BITS:0] top;
      top = v[SUM_W-1:COORD_BITS-1];
      if (top == '0 || top == '1) begin
         return v[COORD_BITS-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_BITS-1){1'b1}}};
      end
   endfunction

   logic signed [COORD_BITS-1:0] q_px, q_py;
   logic signed [SC_W-1:0]       q_sin, q_cos;
   logic signed [19:0]           ox;
   logic signed [17:0]           oy;
   logic                         adv, issue;
   logic [fps_pkg::INDEX_W-1:0]  idx_ff, idx_in;

   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [fps_pkg::INDEX_W-1:0]  s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic signed [COORD_BITS-1:0] s1_px_ff, s1_py_ff, s2_px_ff, s2_py_ff;
   logic signed [PROD_W-1:0]     xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [PROD_W:0]       sum_x, sum_y;
   logic signed [PROD_W+1:0]     rnd_x, rnd_y;
   logic signed [DX_W-1:0]       dx_ff, dy_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;

   assign q_px  = q_data[QW-1 -: COORD_BITS];
   assign q_py  = q_data[QW-COORD_BITS-1 -: COORD_BITS];
   assign q_sin = q_data[2*SC_W-1 -: SC_W];
   assign q_cos = q_data[SC_W-1:0];

   assign adv   = !s3_valid_ff || rsp_pop;
   assign issue = q_valid && adv;
   assign q_pop = issue && (idx_ff == fps_pkg::CIRCLE_BOUND);
   assign idx_in = (idx_ff == fps_pkg::CIRCLE_BOUND) ? fps_pkg::CIRCLE_REAR_LEFT
                                                     : idx_ff + 1'b1;

   always_comb begin
      case (idx_ff)
         fps_pkg::CIRCLE_REAR_LEFT: begin
            ox = 20'(body_width) - {2'b00, rear_length, 2'b00};
            oy = {1'b0, body_width, 1'b0};
         end
         fps_pkg::CIRCLE_REAR_RIGHT: begin
            ox = 20'(body_width) - {2'b00, rear_length, 2'b00};
            oy = -{1'b0, body_width, 1'b0};
         end
         fps_pkg::CIRCLE_FRONT_LEFT: begin
            ox = {2'b00, front_length, 2'b00} - 20'(body_width);
            oy = {1'b0, body_width, 1'b0};
         end
         fps_pkg::CIRCLE_FRONT_RIGHT: begin
            ox = {2'b00, front_length, 2'b00} - 20'(body_width);
            oy = -{1'b0, body_width, 1'b0};
         end
         fps_pkg::CIRCLE_BOUND: begin
            ox = {3'b000, front_length, 1'b0} - {3'b000, rear_length, 1'b0};
            oy = '0;
         end
         default: begin
            ox = '0;
            oy = '0;
         end
      endcase
   end

   assign sum_x = (PROD_W+1)'(xc_ff) - (PROD_W+1)'(ys_ff);
   assign sum_y = (PROD_W+1)'(xs_ff) + (PROD_W+1)'(yc_ff);
   assign rnd_x = (PROD_W+2)'(sum_x) + (PROD_W+2)'(65536);
   assign rnd_y = (PROD_W+2)'(sum_y) + (PROD_W+2)'(65536);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= fps_pkg::CIRCLE_REAR_LEFT;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            idx_ff <= idx_in;
         end
         if (adv) begin
            s1_valid_ff <= issue;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff <= idx_ff;
         s1_px_ff  <= q_px;
         s1_py_ff  <= q_py;
         xc_ff     <= PROD_W'(ox) * PROD_W'(q_cos);
         ys_ff     <= PROD_W'(oy) * PROD_W'(q_sin);
         xs_ff     <= PROD_W'(ox) * PROD_W'(q_sin);
         yc_ff     <= PROD_W'(oy) * PROD_W'(q_cos);

         s2_idx_ff <= s1_idx_ff;
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         dx_ff     <= rnd_x[PROD_W+1:17];
         dy_ff     <= rnd_y[PROD_W+1:17];

         s3_idx_ff <= s2_idx_ff;
         cx_ff     <= saturate(SUM_W'(s2_px_ff) + SUM_W'(dx_ff));
         cy_ff     <= saturate(SUM_W'(s2_py_ff) + SUM_W'(dy_ff));
      end
   end

   assign rsp_empty        = !s3_valid_ff;
   assign rsp_circle_index = s3_idx_ff;
   assign rsp_center_x     = cx_ff;
   assign rsp_center_y     = cy_ff;
   assign rsp_last_circle  = (s3_idx_ff == fps_pkg::CIRCLE_BOUND);
   assign rsp_radius       = rsp_last_circle ? radii.bound : radii.corner;

endmodule

@@ sv/vehicle_footprint_circle_transform.sv @@
// ----------------------------------------------------------------------------
// Vehicle footprint circle transform
// Turns each vehicle pose into four corner collision circles and one bounding
// circle in world coordinates.
// ----------------------------------------------------------------------------
// Each pose request yields five results in the order rear-left, rear-right,
// front-left, front-right and bounding circle, the last one flagged. The back
// end issues one circle per cycle while its results are taken, and the front
// end takes a pose every cycle until its two-entry queue fills. After reset
// and after every register write the two radii are recomputed; meanwhile full
// is high and the register port is not ready.
module vehicle_footprint_circle_transform #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int COORD_BITS       = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [COORD_BITS-1:0]        req_pose_x,
   input  logic signed [COORD_BITS-1:0]        req_pose_y,
   input  logic [fps_pkg::HEADING_W-1:0]       req_pose_heading,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [fps_pkg::INDEX_W-1:0]         rsp_circle_index,
   output logic signed [COORD_BITS-1:0]        rsp_center_x,
   output logic signed [COORD_BITS-1:0]        rsp_center_y,
   output logic [fps_pkg::RADIUS_W-1:0]        rsp_radius,
   output logic                                rsp_last_circle,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fps_pkg::LENGTH_W-1:0]        csr_wdata
);

   localparam int QW = 2*COORD_BITS + 2*fps_pkg::SINCOS_W;

   logic [fps_pkg::LENGTH_W-1:0] front_length_ff, rear_length_ff, body_width_ff;
   logic                         csr_write;
   logic                         busy;
   fps_pkg::radii_type           radii;
   logic                         q_push, q_full, q_pop, q_valid;
   logic [QW-1:0]                q_push_data, q_pop_data;

   assign csr_ready = !busy;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_length_ff <= 16'd768;
         rear_length_ff  <= 16'd256;
         body_width_ff   <= 16'd512;
      end else if (csr_write) begin
         case (csr_index)
            fps_pkg::REG_FRONT_LENGTH: front_length_ff <= csr_wdata;
            fps_pkg::REG_REAR_LENGTH:  rear_length_ff  <= csr_wdata;
            fps_pkg::REG_BODY_WIDTH:   body_width_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   fps_radius u_radius (
      .clock        (clock),
      .reset        (reset),
      .start        (csr_write),
      .front_length (front_length_ff),
      .rear_length  (rear_length_ff),
      .body_width   (body_width_ff),
      .busy         (busy),
      .radii        (radii)
   );

   fps_front #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .COORD_BITS       (COORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .busy             (busy),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_pose_heading (req_pose_heading),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   fps_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   fps_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .front_length     (front_length_ff),
      .rear_length      (rear_length_ff),
      .body_width       (body_width_ff),
      .radii            (radii),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_circle_index (rsp_circle_index),
      .rsp_center_x     (rsp_center_x),
      .rsp_center_y     (rsp_center_y),
      .rsp_radius       (rsp_radius),
      .rsp_last_circle  (rsp_last_circle)
   );

endmodule
